>>> design/gmerge_pkg.sv
// Shared types, constants and helpers for the gap-method merge unit.
`default_nettype none
package gmerge_pkg;
	localparam int MAX_LIST    = 32;
	localparam int STORE_DEPTH = 2 * MAX_LIST;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int EFF_W       = $clog2(MAX_LIST + 1);
	localparam int DATA_W      = 64;
	localparam int LEN_W       = 6;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SECOND = CFG_IDX_W'(1);
	localparam logic [LEN_W-1:0]     COUNT_RESET = LEN_W'(32);

	typedef struct packed {
		logic [EFF_W-1:0] first;
		logic [CNT_W-1:0] total;
	} cfg_t;

	typedef struct packed {
		logic                     we;
		logic [ADDR_W-1:0]        waddr;
		logic signed [DATA_W-1:0] wdata;
		logic [ADDR_W-1:0]        raddr;
	} ram_req_t;

	// zero acts as one, anything above the store half acts as the maximum
	function automatic logic [EFF_W-1:0] eff_count(input logic [LEN_W-1:0] r);
		logic [EFF_W-1:0] res;
		if (r == '0) begin
			res = EFF_W'(1);
		end else if (int'(r) > MAX_LIST) begin
			res = EFF_W'(MAX_LIST);
		end else begin
			res = EFF_W'(r);
		end
		return res;
	endfunction

	// ceil(g/2), with 1 and 0 ending the sequence
	function automatic logic [CNT_W-1:0] next_gap(input logic [CNT_W-1:0] g);
		logic [CNT_W-1:0] res;
		if (g <= CNT_W'(1)) begin
			res = '0;
		end else begin
			res = (g >> 1) + {{(CNT_W-1){1'b0}}, g[0]};
		end
		return res;
	endfunction
endpackage
`default_nettype wire

>>> design/gmerge_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gmerge_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> design/gmerge_cfg.sv
// Length registers and their clamped view.
`default_nettype none
module gmerge_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	input  wire logic [gmerge_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gmerge_pkg::LEN_W-1:0]    cfg_data,
	output logic                                 cfg_ready,
	output gmerge_pkg::cfg_t                     cfg
);
	import gmerge_pkg::*;

	logic [LEN_W-1:0] first_q;
	logic [LEN_W-1:0] second_q;
	logic [EFF_W-1:0] first_eff;
	logic [EFF_W-1:0] second_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= COUNT_RESET;
			second_q <= COUNT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FIRST:  first_q  <= cfg_data;
				REG_SECOND: second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign first_eff  = eff_count(first_q);
	assign second_eff = eff_count(second_q);
	assign cfg.first  = first_eff;
	assign cfg.total  = CNT_W'(first_eff) + CNT_W'(second_eff);
endmodule
`default_nettype wire

>>> design/gmerge_ctrl.sv
// Load, gap-pass compare-swap and emit sequencer around the element RAM.
`default_nettype none
module gmerge_ctrl (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [gmerge_pkg::DATA_W-1:0] value,
	input  wire gmerge_pkg::cfg_t                  cfg,
	input  wire logic signed [gmerge_pkg::DATA_W-1:0] rd_data,
	output logic                                   busy,
	output gmerge_pkg::ram_req_t                   ram_req,
	output logic                                   res_valid,
	output logic                                   in_second,
	output logic                                   is_last
);
	import gmerge_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD_A = 3'd1;
	localparam logic [2:0] ST_RD_B = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_WR_B = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0]               state_q, state_d;
	logic [CNT_W-1:0]         lc_q, lc_d;
	logic [ADDR_W-1:0]        idx_q, idx_d;
	logic [CNT_W-1:0]         gap_q, gap_d;
	logic [CNT_W-1:0]         k_q, k_d;
	logic [CNT_W-1:0]         total_q, total_d;
	logic [EFF_W-1:0]         first_q, first_d;
	logic signed [DATA_W-1:0] a_q;
	logic                     valid_s1, second_s1, last_s1;

	logic             accept, lc_room, batch_done, swap, more_pairs, emit;
	logic [CNT_W-1:0] lc_next, partner, idx_inc, gap_nx, k_inc;
	logic [2:0]       adv_state;
	logic [ADDR_W-1:0] adv_idx;
	logic [CNT_W-1:0] adv_gap;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && (state_q == ST_IDLE);
	assign lc_room    = (lc_q < CNT_W'(STORE_DEPTH));
	assign lc_next    = lc_q + {{(CNT_W-1){1'b0}}, lc_room};
	assign batch_done = (lc_next >= cfg.total);
	assign partner    = CNT_W'(idx_q) + gap_q;
	assign idx_inc    = CNT_W'(idx_q) + CNT_W'(1);
	assign more_pairs = ((idx_inc + gap_q) < total_q);
	assign gap_nx     = next_gap(gap_q);
	assign swap       = (a_q > rd_data);
	assign emit       = (state_q == ST_EMIT);
	assign k_inc      = k_q + CNT_W'(1);

	// step to the next pair, the next pass, or out to emit
	always_comb begin
		adv_state = ST_RD_A;
		adv_idx   = '0;
		adv_gap   = gap_q;
		if (more_pairs) begin
			adv_idx = idx_inc[ADDR_W-1:0];
		end else if (gap_nx == '0) begin
			adv_state = ST_EMIT;
		end else begin
			adv_gap = gap_nx;
		end
	end

	always_comb begin
		ram_req.we    = 1'b0;
		ram_req.waddr = lc_q[ADDR_W-1:0];
		ram_req.wdata = value;
		ram_req.raddr = idx_q;
		case (state_q)
			ST_IDLE: ram_req.we = accept && lc_room;
			ST_RD_B: ram_req.raddr = partner[ADDR_W-1:0];
			ST_CMP: begin
				ram_req.we    = swap;
				ram_req.waddr = idx_q;
				ram_req.wdata = rd_data;
			end
			ST_WR_B: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = partner[ADDR_W-1:0];
				ram_req.wdata = a_q;
			end
			ST_EMIT: ram_req.raddr = k_q[ADDR_W-1:0];
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		lc_d    = lc_q;
		idx_d   = idx_q;
		gap_d   = gap_q;
		k_d     = k_q;
		total_d = total_q;
		first_d = first_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (batch_done) begin
						lc_d    = '0;
						total_d = cfg.total;
						first_d = cfg.first;
						gap_d   = next_gap(cfg.total);
						idx_d   = '0;
						state_d = ST_RD_A;
					end else begin
						lc_d = lc_next;
					end
				end
			end
			ST_RD_A: state_d = ST_RD_B;
			ST_RD_B: state_d = ST_CMP;
			ST_CMP: begin
				if (swap) begin
					state_d = ST_WR_B;
				end else begin
					state_d = adv_state;
					idx_d   = adv_idx;
					gap_d   = adv_gap;
					k_d     = '0;
				end
			end
			ST_WR_B: begin
				state_d = adv_state;
				idx_d   = adv_idx;
				gap_d   = adv_gap;
				k_d     = '0;
			end
			ST_EMIT: begin
				k_d = k_inc;
				if (k_inc == total_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			lc_q      <= '0;
			valid_s1  <= 1'b0;
			second_s1 <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			lc_q      <= lc_d;
			valid_s1  <= emit;
			second_s1 <= emit && (k_q >= CNT_W'(first_q));
			last_s1   <= emit && (k_inc == total_q);
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		gap_q   <= gap_d;
		k_q     <= k_d;
		total_q <= total_d;
		first_q <= first_d;
		if (state_q == ST_RD_B) begin
			a_q <= rd_data;
		end
	end

	assign res_valid = valid_s1;
	assign in_second = second_s1;
	assign is_last   = last_s1;
endmodule
`default_nettype wire

>>> design/gap_merge_two_sorted_lists_unit.sv
// Top level of the gap-method merge unit.
//
// Usage: set the two list lengths on the cfg channel (index 0 first list,
// index 1 second list, 1..32 each; 0 acts as 1, larger acts as 32) while
// the unit is idle. cfg_ready is always high.
// Send the first list and then the second list one value per request:
// a request is taken when start is high and busy is low. While loading,
// the unit can take a value every cycle and busy stays low.
// On the value that completes the batch (n+m values) busy rises and the
// unit merges the RAM in place with gap passes: about ceil(log2(n+m))
// passes, each over (n+m-gap) pairs that step through two reads and a
// compare, plus write-backs when the pair swaps. The RAM has a single
// read port: each pair is two reads and up to two writes. The unit then
// reads out all n+m values, one per cycle: res_valid strobes for one cycle
// per result, with value_res, in_second and is_last; results are back to
// back and the receiver cannot stall them. busy falls in the same cycle as
// the last result shows. Reset clears the load count and restores both
// lengths to 32; stored values are not cleared.
`default_nettype none
module gap_merge_two_sorted_lists_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic signed [gmerge_pkg::DATA_W-1:0] value,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [gmerge_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [gmerge_pkg::LEN_W-1:0]         cfg_data,
	output logic                                      res_valid,
	output logic signed [gmerge_pkg::DATA_W-1:0]      value_res,
	output logic                                      in_second,
	output logic                                      is_last
);
	import gmerge_pkg::*;

	cfg_t                     cfg;
	ram_req_t                 ram_req;
	logic signed [DATA_W-1:0] rd_data;

	gmerge_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	gmerge_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (rd_data)
	);

	gmerge_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.cfg       (cfg),
		.rd_data   (rd_data),
		.busy      (busy),
		.ram_req   (ram_req),
		.res_valid (res_valid),
		.in_second (in_second),
		.is_last   (is_last)
	);

	assign value_res = rd_data;
endmodule
`default_nettype wire

>>> design/gmerge_chk.sv
// Port-level checks for the merge unit, bound to the top level.
`default_nettype none
module gmerge_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic busy,
	input wire logic res_valid,
	input wire logic in_second,
	input wire logic is_last
);
	// every result follows a cycle of busy
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(busy))
		else $error("result without preceding busy cycle");

	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		is_last |-> res_valid)
		else $error("is_last without result strobe");

	a_second_marked: assert property (@(posedge clk) disable iff (!arst_n)
		in_second |-> res_valid)
		else $error("in_second without result strobe");

	// results of one batch come out back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !is_last |=> res_valid)
		else $error("gap inside result burst");
endmodule

bind gap_merge_two_sorted_lists_unit gmerge_chk u_chk (.*);
`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for the gap-method merge unit: mostly sorted list pairs under swept lengths.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gmerge_pkg::*;

	localparam int HALF_PERIOD      = 2;
	localparam int RESET_CYCLES     = 12;
	localparam int RANDOM_ITEMS     = 300;
	localparam int SETTLE_CYCLES    = 6;
	localparam int DRAIN_CYCLES     = 8;
	localparam int QUIET_LIMIT      = 20000;
	localparam int SHOWN_MISMATCHES = 10;

	localparam logic [CFG_IDX_W-1:0]     REG_SPARE = CFG_IDX_W'(3);
	localparam logic signed [DATA_W-1:0] WORD_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] WORD_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic {REQ_VALUE, REQ_CFG} req_kind_t;

	typedef struct {
		req_kind_t                kind;
		logic signed [DATA_W-1:0] word;
		logic [CFG_IDX_W-1:0]     idx;
		logic [LEN_W-1:0]         len;
		int unsigned              idle_pct;
	} request_t;

	typedef struct {
		logic signed [DATA_W-1:0] word;
		logic                     in_second;
		logic                     is_last;
	} merged_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        start     = 1'b0;
	logic                        busy;
	logic signed [DATA_W-1:0]    value     = '0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [LEN_W-1:0]            cfg_data  = '0;
	logic                        res_valid;
	logic signed [DATA_W-1:0]    value_res;
	logic                        in_second;
	logic                        is_last;

	// handshakes seen at the last rising edge
	logic item_taken = 1'b0;
	logic cfg_taken  = 1'b0;

	request_t    pending_reqs[$];
	int unsigned planned_items = 0;
	int unsigned phase_pct     = 0;
	logic [LEN_W-1:0] plan_first  = COUNT_RESET;
	logic [LEN_W-1:0] plan_second = COUNT_RESET;

	// predictor state
	logic [LEN_W-1:0]         first_len  = COUNT_RESET;
	logic [LEN_W-1:0]         second_len = COUNT_RESET;
	logic signed [DATA_W-1:0] joined_store [STORE_DEPTH];
	int unsigned              fill_count = 0;
	merged_t                  merged_due[$];

	int unsigned mismatches   = 0;
	int unsigned quiet_cycles = 0;
	int unsigned settle       = 0;

	gap_merge_two_sorted_lists_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.value_res (value_res),
		.in_second (in_second),
		.is_last   (is_last)
	);

	always #HALF_PERIOD clk = ~clk;

	// zero acts as one, anything past the half store acts as the maximum
	function automatic int unsigned list_len(input logic [LEN_W-1:0] r);
		if (r == '0)
			return 1;
		if (int'(r) > MAX_LIST)
			return MAX_LIST;
		return int'(r);
	endfunction

	function automatic int unsigned plan_total();
		return list_len(plan_first) + list_len(plan_second);
	endfunction

	// load one value; on the completing one, gap-merge the batch and queue its results
	task automatic merge_joined_store(input logic signed [DATA_W-1:0] w);
		int unsigned n;
		int unsigned total;
		int unsigned gap;
		int unsigned i;
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
		merged_t m;
		n = list_len(first_len);
		total = n + list_len(second_len);
		if (fill_count < STORE_DEPTH) begin
			joined_store[fill_count] = w;
			fill_count++;
		end
		if (fill_count >= total) begin
			gap = (total + 1) / 2;
			while (gap > 0) begin
				for (i = 0; i + gap < total; i++) begin
					lo = joined_store[i];
					hi = joined_store[i + gap];
					if (lo > hi) begin
						joined_store[i] = hi;
						joined_store[i + gap] = lo;
					end
				end
				gap = (gap <= 1) ? 0 : (gap + 1) / 2;
			end
			for (i = 0; i < total; i++) begin
				m.word = joined_store[i];
				m.in_second = (i >= n);
				m.is_last = (i + 1 == total);
				merged_due.push_back(m);
			end
			fill_count = 0;
		end
	endtask

	task automatic flag_result(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		mismatches++;
		if (mismatches <= SHOWN_MISMATCHES)
			$display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
	endtask

	// monitor: checks results, then feeds accepted requests to the predictor
	always @(posedge clk) begin : watch_ports
		merged_t m;
		if (arst_n) begin
			item_taken <= start && !busy;
			cfg_taken <= cfg_valid && cfg_ready;
			if (res_valid) begin
				if (merged_due.size() == 0) begin
					flag_result("result with nothing due", 'x, value_res);
				end else begin
					m = merged_due.pop_front();
					if (value_res !== m.word)
						flag_result("value_res", m.word, value_res);
					if (in_second !== m.in_second)
						flag_result("in_second", DATA_W'(m.in_second), DATA_W'(in_second));
					if (is_last !== m.is_last)
						flag_result("is_last", DATA_W'(m.is_last), DATA_W'(is_last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FIRST: begin
						first_len = cfg_data;
					end
					REG_SECOND: begin
						second_len = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (start && !busy)
				merge_joined_store(value);
		end
	end

	// driver: one request at a time; config writes only once the unit has gone quiet
	always @(negedge clk) begin : drive_requests
		logic nxt_start;
		logic nxt_cfg;
		request_t r;
		nxt_start = start && !item_taken;
		nxt_cfg = cfg_valid && !cfg_taken;
		if (arst_n && !nxt_start && !nxt_cfg && pending_reqs.size() != 0) begin
			r = pending_reqs[0];
			if (r.kind == REQ_VALUE) begin
				settle = 0;
				if ($urandom_range(99) >= r.idle_pct) begin
					void'(pending_reqs.pop_front());
					value <= r.word;
					nxt_start = 1'b1;
				end
			end else if (busy || merged_due.size() != 0) begin
				settle = 0;
			end else if (settle < SETTLE_CYCLES) begin
				settle++;
			end else begin
				settle = 0;
				void'(pending_reqs.pop_front());
				cfg_index <= r.idx;
				cfg_data <= r.len;
				nxt_cfg = 1'b1;
			end
		end
		start <= nxt_start;
		cfg_valid <= nxt_cfg;
	end

	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || (cfg_valid && cfg_ready) || res_valid))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic push_value(input logic signed [DATA_W-1:0] w);
		request_t r;
		r.kind = REQ_VALUE;
		r.word = w;
		r.idx = '0;
		r.len = '0;
		r.idle_pct = phase_pct;
		pending_reqs.push_back(r);
		planned_items++;
	endtask

	task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] len);
		request_t r;
		r.kind = REQ_CFG;
		r.word = '0;
		r.idx = idx;
		r.len = len;
		r.idle_pct = phase_pct;
		pending_reqs.push_back(r);
		if (idx == REG_FIRST)
			plan_first = len;
		else if (idx == REG_SECOND)
			plan_second = len;
	endtask

	// 0: full range, 1: tiny range with many ties, 2: near the extremes, else a mix
	function automatic logic signed [DATA_W-1:0] rand_word(input int style);
		int small_v;
		int pick;
		pick = (style > 2) ? int'($urandom_range(2)) : style;
		case (pick)
			0: begin
				return {$urandom, $urandom};
			end
			1: begin
				small_v = $urandom_range(8);
				return DATA_W'(small_v - 4);
			end
			default: begin
				case ($urandom_range(5))
					0: return WORD_MIN;
					1: return WORD_MIN + 1;
					2: return -1;
					3: return 0;
					4: return WORD_MAX - 1;
					default: return WORD_MAX;
				endcase
			end
		endcase
	endfunction

	task automatic push_list(input int len, input int style, input bit ordered);
		logic signed [DATA_W-1:0] vals[$];
		logic signed [DATA_W-1:0] t;
		int i;
		int j;
		for (i = 0; i < len; i++)
			vals.push_back(rand_word(style));
		if (ordered) begin
			for (i = 1; i < len; i++) begin
				t = vals[i];
				j = i - 1;
				while (j >= 0 && vals[j] > t) begin
					vals[j + 1] = vals[j];
					j--;
				end
				vals[j + 1] = t;
			end
		end
		for (i = 0; i < len; i++)
			push_value(vals[i]);
	endtask

	// mostly short lists, now and then a length at or past the ends of the range
	function automatic logic [LEN_W-1:0] pick_len();
		if ($urandom_range(99) < 8) begin
			case ($urandom_range(5))
				0: return LEN_W'(0);
				1: return LEN_W'(1);
				2: return LEN_W'(31);
				3: return LEN_W'(32);
				4: return LEN_W'(33);
				default: return LEN_W'(63);
			endcase
		end
		return LEN_W'($urandom_range(6, 1));
	endfunction

	initial begin : stimulus
		int unsigned first_random;
		int unsigned done_rand;
		int unsigned phase;
		int k;
		int tot;
		int style;
		int shape;

		// both lengths zero: one value each
		push_cfg(REG_FIRST, LEN_W'(0));
		push_cfg(REG_SECOND, LEN_W'(0));
		push_value(WORD_MAX);
		push_value(WORD_MIN);
		// one against three, with ties
		push_cfg(REG_FIRST, LEN_W'(1));
		push_cfg(REG_SECOND, LEN_W'(3));
		push_value(0);
		push_value(-1);
		push_value(-1);
		push_value(5);
		// write to an unused index must change nothing
		push_cfg(REG_SPARE, LEN_W'(63));
		push_cfg(REG_SECOND, LEN_W'(1));
		push_value(WORD_MIN);
		push_value(WORD_MIN);
		// shrink mid-load below the loaded count: next value completes the batch
		push_cfg(REG_FIRST, LEN_W'(2));
		push_cfg(REG_SECOND, LEN_W'(2));
		push_value(9);
		push_value(4);
		push_value(-3);
		push_cfg(REG_FIRST, LEN_W'(1));
		push_cfg(REG_SECOND, LEN_W'(1));
		push_value(7);
		// grow mid-load: loaded values are kept
		push_value(-8);
		push_cfg(REG_FIRST, LEN_W'(2));
		push_cfg(REG_SECOND, LEN_W'(3));
		push_value(3);
		push_value(-2);
		push_value(1);
		push_value(6);

		first_random = planned_items;
		while (planned_items < first_random + RANDOM_ITEMS) begin
			done_rand = planned_items - first_random;
			phase = done_rand * 4 / RANDOM_ITEMS;
			case (phase)
				1: phase_pct = 46;
				3: phase_pct = 38;
				default: phase_pct = 0;
			endcase
			if ($urandom_range(99) < 60)
				push_cfg(REG_FIRST, pick_len());
			if ($urandom_range(99) < 60)
				push_cfg(REG_SECOND, pick_len());
			if ($urandom_range(99) < 4)
				push_cfg(REG_SPARE, LEN_W'($urandom));
			style = $urandom_range(3);
			shape = $urandom_range(9);
			if (shape == 0) begin
				tot = plan_total();
				k = $urandom_range(tot - 1, 1);
				push_list(k, style, 1'b1);
				push_cfg(REG_FIRST, pick_len());
				push_cfg(REG_SECOND, pick_len());
				tot = plan_total();
				push_list((k >= tot) ? 1 : tot - k, style, 1'b1);
			end else if (shape == 1) begin
				push_list(plan_total(), style, 1'b0);
			end else begin
				push_list(list_len(plan_first), style, 1'b1);
				push_list(list_len(plan_second), style, 1'b1);
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || start || cfg_valid)
			@(posedge clk);
		while (merged_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
